@@ sv/dtep_pkg.sv @@
// ---------------------------------------------------------------------------
// dtep_pkg: shared types and constants for the date-time text converter
// Holds the parsed date-time record that travels from the parser to the
// converter, and the day-count helpers used by the converter.
// ---------------------------------------------------------------------------
package dtep_pkg;

    localparam int YEAR_W   = 14;
    localparam int EPOCH_W  = 39;

    // One parsed string, as the parser hands it to the converter
    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } rec_t;

    // Era length and epoch offset of the civil-day count
    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [19:0] EPOCH_DAY_OFS  = 20'd719468;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;

    // Reciprocal of 400 scaled by 2^21; exact floor for years below 10000
    localparam logic [12:0] ERA_RECIP      = 13'd5243;
    localparam int          ERA_SHIFT      = 21;

    // Days from March 1 to the first of a March-based month (0 = March)
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

@@ sv/dtep_parse.sv @@
// ---------------------------------------------------------------------------
// dtep_parse: character parser
// Takes one character per transaction, tracks the date-time fields and
// pushes one record into the queue at the last character of each string.
// ---------------------------------------------------------------------------
module dtep_parse (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,    // [7:0] ch
    input  logic           s_tlast,    // last
    input  logic           q_full,
    output logic           q_push,
    output dtep_pkg::rec_t q_rec
);
    import dtep_pkg::*;

    typedef enum logic [3:0] {
        PH_SKIP, PH_YEAR, PH_SEP_A, PH_MONTH, PH_SEP_B, PH_DAY, PH_AFTER_DAY,
        PH_HOUR, PH_COLON, PH_MINUTE, PH_AFTER_MIN, PH_SECOND, PH_DONE, PH_FAIL
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [1:0]        digit_reg,  digit_next;
    logic [YEAR_W-1:0] year_reg,   year_next;
    logic [6:0]        month_reg,  month_next;
    logic [6:0]        day_reg,    day_next;
    logic [6:0]        hour_reg,   hour_next;
    logic [6:0]        minute_reg, minute_next;
    logic [6:0]        second_reg, second_next;

    logic              accept;
    logic              is_digit, is_blank, is_sep;
    logic [3:0]        digit_val;
    logic              take_en;
    logic [YEAR_W-1:0] field_val, acc, lo, hi;
    logic [1:0]        last_idx;
    phase_t            goal;
    logic              ok_next;

    // Accept a character whenever the queue can take a record
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign is_digit  = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    assign is_blank  = (s_tdata == 8'h20) || (s_tdata == 8'h09);
    assign is_sep    = (s_tdata == 8'h3A) || (s_tdata == 8'h2D);
    assign digit_val = s_tdata[3:0];

    // Select the field that the current phase fills and its limits
    always_comb begin
        take_en   = 1'b0;
        field_val = '0;
        lo        = '0;
        hi        = '0;
        last_idx  = 2'd1;
        goal      = PH_FAIL;
        case (phase_reg)
            PH_SKIP, PH_YEAR: begin
                take_en   = !(phase_reg == PH_SKIP && is_blank);
                field_val = year_reg;
                lo        = 14'd1;
                hi        = 14'd9999;
                last_idx  = 2'd3;
                goal      = PH_SEP_A;
            end
            PH_MONTH: begin
                take_en   = 1'b1;
                field_val = YEAR_W'(month_reg);
                lo        = 14'd1;
                hi        = 14'd12;
                goal      = PH_SEP_B;
            end
            PH_DAY: begin
                take_en   = 1'b1;
                field_val = YEAR_W'(day_reg);
                lo        = 14'd1;
                hi        = 14'd31;
                goal      = PH_AFTER_DAY;
            end
            PH_HOUR: begin
                take_en   = 1'b1;
                field_val = YEAR_W'(hour_reg);
                hi        = 14'd23;
                goal      = PH_COLON;
            end
            PH_MINUTE: begin
                take_en   = 1'b1;
                field_val = YEAR_W'(minute_reg);
                hi        = 14'd59;
                goal      = PH_AFTER_MIN;
            end
            PH_SECOND: begin
                take_en   = 1'b1;
                field_val = YEAR_W'(second_reg);
                hi        = 14'd60;
                goal      = PH_DONE;
            end
            default: begin
                take_en = 1'b0;
            end
        endcase
    end

    assign acc = YEAR_W'(field_val * 14'd10 + YEAR_W'(digit_val));

    // Advance the parser by one character
    always_comb begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (accept) begin
            if (take_en) begin
                if (!is_digit) begin
                    phase_next = PH_FAIL;
                end else begin
                    case (phase_reg)
                        PH_SKIP, PH_YEAR: year_next = acc;
                        PH_MONTH:         month_next  = acc[6:0];
                        PH_DAY:           day_next    = acc[6:0];
                        PH_HOUR:          hour_next   = acc[6:0];
                        PH_MINUTE:        minute_next = acc[6:0];
                        default:          second_next = acc[6:0];
                    endcase
                    phase_next = (phase_reg == PH_SKIP) ? PH_YEAR : phase_reg;
                    digit_next = digit_reg + 2'd1;
                    if (digit_reg == last_idx) begin
                        digit_next = 2'd0;
                        phase_next = (acc >= lo && acc <= hi) ? goal : PH_FAIL;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_SEP_A:     phase_next = is_sep ? PH_MONTH : PH_FAIL;
                    PH_SEP_B:     phase_next = is_sep ? PH_DAY : PH_FAIL;
                    PH_AFTER_DAY: phase_next = (s_tdata == 8'h20 || s_tdata == 8'h54) ?
                                               PH_HOUR : PH_DONE;
                    PH_COLON:     phase_next = (s_tdata == 8'h3A) ? PH_MINUTE : PH_FAIL;
                    PH_AFTER_MIN: phase_next = (s_tdata == 8'h3A) ? PH_SECOND : PH_DONE;
                    default:      phase_next = phase_reg;
                endcase
            end
        end
    end

    // Build the record from the updated fields at the last character
    assign ok_next = (phase_next == PH_AFTER_DAY) || (phase_next == PH_AFTER_MIN) ||
                     (phase_next == PH_DONE);
    assign q_push  = accept && s_tlast;
    always_comb begin
        q_rec.ok     = ok_next;
        q_rec.year   = year_next;
        q_rec.month  = month_next[3:0];
        q_rec.day    = day_next[4:0];
        q_rec.hour   = hour_next[4:0];
        q_rec.minute = minute_next[5:0];
        q_rec.second = second_next[5:0];
    end

    // Hold parser state; clear it after each string
    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            phase_reg  <= PH_SKIP;
            digit_reg  <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            digit_reg  <= digit_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

endmodule

@@ sv/dtep_queue.sv @@
// ---------------------------------------------------------------------------
// dtep_queue: record queue
// Small first-in first-out buffer of parsed records between the parser
// and the converter, so that either side can stall on its own.
// ---------------------------------------------------------------------------
module dtep_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dtep_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output dtep_pkg::rec_t head_rec
);
    import dtep_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    // Store pushed records
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ sv/dtep_conv.sv @@
// ---------------------------------------------------------------------------
// dtep_conv: epoch converter
// Pops one parsed record at a time and turns it into signed seconds since
// 1970-01-01 over a short sequence of registered steps.
// ---------------------------------------------------------------------------
module dtep_conv (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  dtep_pkg::rec_t      q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [38:0] epoch_seconds
    output logic                m_tuser    // ok
);
    import dtep_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ERA, ST_DOE, ST_DAYS, ST_SCALE, ST_OUT
    } state_t;

    state_t                    state_reg;
    rec_t                      rec_reg;
    logic [YEAR_W-1:0]         y_reg;
    logic [3:0]                mp_reg;
    logic [4:0]                era_reg;
    logic [16:0]               tod_reg;
    logic [17:0]               doe_reg;
    logic signed [22:0]        days_reg;
    logic signed [EPOCH_W-1:0] scaled_reg;
    logic                      valid_reg;
    logic                      ok_reg;
    logic [EPOCH_W-1:0]        epoch_reg;

    logic [YEAR_W-1:0]         y_next;
    logic [3:0]                mp_next;
    logic [26:0]               era_prod;
    logic [4:0]                era_next;
    logic [16:0]               tod_next;
    logic [8:0]                yoe;
    logic [1:0]                cent;
    logic [8:0]                doy;
    logic [17:0]               doe_next;
    logic [22:0]               era_days;
    logic signed [22:0]        days_next;
    logic signed [40:0]        scaled_full;
    logic signed [EPOCH_W-1:0] sum_next;
    logic                      out_free;

    // Shift the year to start in March, split off the era and sum the time of day
    assign y_next   = (rec_reg.month <= 4'd2) ? rec_reg.year - YEAR_W'(1) : rec_reg.year;
    assign mp_next  = (rec_reg.month > 4'd2) ? rec_reg.month - 4'd3 : rec_reg.month + 4'd9;
    assign era_prod = 27'(y_next) * 27'(ERA_RECIP);
    assign era_next = era_prod[ERA_SHIFT +: 5];
    assign tod_next = 17'(rec_reg.hour) * 17'(SECS_PER_HOUR) + 17'(rec_reg.minute * 12'd60)
                      + 17'(rec_reg.second);

    // Day of era from year of era and day of year
    assign yoe      = 9'(y_reg - YEAR_W'(era_reg) * YEAR_W'(YEARS_PER_ERA));
    assign cent     = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
                      (yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign doy      = month_start(mp_reg) + 9'(rec_reg.day) - 9'd1;
    assign doe_next = 18'(yoe) * 18'(DAYS_PER_YEAR) + 18'(yoe >> 2) - 18'(cent) + 18'(doy);

    // Days relative to the epoch
    assign era_days  = 23'(era_reg) * 23'(DAYS_PER_ERA) + 23'(doe_reg);
    assign days_next = signed'(era_days - 23'(EPOCH_DAY_OFS));

    // Scale to seconds and add the time of day
    assign scaled_full = days_reg * $signed({1'b0, SECS_PER_DAY});
    assign sum_next    = scaled_reg + $signed({22'd0, tod_reg});

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    assign m_tvalid = valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {1'b0, epoch_reg};

    // Sequence one record through the conversion and hold the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            // Raise valid with a new result, drop it once the transaction is taken
            if (state_reg == ST_OUT && out_free) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        rec_reg   <= q_head;
                        state_reg <= ST_ERA;
                    end
                end
                ST_ERA: begin
                    y_reg     <= y_next;
                    mp_reg    <= mp_next;
                    era_reg   <= era_next;
                    tod_reg   <= tod_next;
                    state_reg <= ST_DOE;
                end
                ST_DOE: begin
                    doe_reg   <= doe_next;
                    state_reg <= ST_DAYS;
                end
                ST_DAYS: begin
                    days_reg  <= days_next;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    scaled_reg <= scaled_full[EPOCH_W-1:0];
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        ok_reg    <= rec_reg.ok;
                        epoch_reg <= rec_reg.ok ? sum_next : '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/datetime_text_to_epoch_seconds.sv @@
// ---------------------------------------------------------------------------
// datetime_text_to_epoch_seconds: date-time text to epoch seconds
// Streams a date-time string in, one character per transaction, and
// returns an ok flag and signed seconds since 1970-01-01 per string.
// ---------------------------------------------------------------------------
// The parser takes one character per cycle while the queue has room and, at
// the character marked last, drops one parsed record into a queue of
// QUEUE_DEPTH entries. The converter drains that queue one record at a time
// through a sequence of registered steps (pop, era split, day of era, epoch
// day, scale, output register) and pops a new record only after the last
// one has left the output step, so a run of short strings is paced by the
// converter; the converter also holds at the output step while the output
// side is not ready, and s_tready drops while the queue is full. Output
// m_tuser carries the ok flag and m_tdata the seconds, which are zero when
// ok is low.
module datetime_text_to_epoch_seconds #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [38:0] epoch_seconds, [39] zero
    output logic        m_tuser    // ok
);
    import dtep_pkg::*;

    logic q_full, q_push, q_pop, q_empty;
    rec_t push_rec, head_rec;

    dtep_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    dtep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_rec (head_rec)
    );

    dtep_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
